// File: hw/rtl/fptrt_pkg.sv
// Shared types, constants and helpers for the fixed-point to radix text converter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fptrt_pkg;

    localparam int VALUE_W = 32;
    localparam int FB_IN_W = 6;
    localparam int FB_W = 5;
    localparam int RADIX_W = 5;
    localparam int LIM_W = 4;
    localparam int CHAR_W = 8;
    localparam int ERR_W = 2;

    localparam int MAX_FRAC_DIGITS = 15;
    localparam int MAX_FRAC_BITS = 31;
    localparam int MIN_RADIX = 2;
    localparam int MAX_RADIX = 16;

    localparam int DIGIT_W = 4;
    localparam int DIGIT_DEPTH = 32;
    localparam int DIGIT_IDX_W = $clog2(DIGIT_DEPTH);
    localparam int DIGIT_CNT_W = DIGIT_IDX_W + 1;

    localparam int DIV_BITS_PER_CYCLE = 8;
    localparam int DIV_CYCLES = VALUE_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_STEP_W = $clog2(DIV_CYCLES);

    localparam int PROD_W = VALUE_W + DIGIT_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_IDX_W + 1;

    localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2e;
    localparam logic [16*CHAR_W-1:0] DIGIT_CHARS = "0123456789abcdef";

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_FRAC_BITS  = 2'd1,
        ERR_RADIX_LOW  = 2'd2,
        ERR_RADIX_HIGH = 2'd3
    } err_t;

    typedef struct packed {
        err_t                 err;
        logic                 neg;
        logic [VALUE_W-1:0]   whole;
        logic [VALUE_W-1:0]   frac;
        logic [FB_W-1:0]      fb;
        logic [RADIX_W-1:0]   radix;
        logic [LIM_W-1:0]     lim;
    } conv_item_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        return DIGIT_CHARS[CHAR_W*(15 - int'(d)) +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fptrt_front.sv
// Front end: checks an incoming request and splits the value into sign, whole and fraction.
// Depends on fptrt_pkg.
`default_nettype none

module fptrt_front (
    input  wire logic [fptrt_pkg::VALUE_W-1:0] value,
    input  wire logic [fptrt_pkg::FB_IN_W-1:0] frac_bits,
    input  wire logic [fptrt_pkg::RADIX_W-1:0] radix,
    input  wire logic [fptrt_pkg::LIM_W-1:0]   frac_digits,
    output fptrt_pkg::conv_item_t              item
);
    import fptrt_pkg::*;

    logic [VALUE_W-1:0] mag;
    logic [FB_W-1:0]    fb;
    logic [VALUE_W-1:0] mask;

    assign mag  = value[VALUE_W-1] ? (~value + 1'b1) : value;
    assign fb   = FB_W'(frac_bits);
    assign mask = (VALUE_W'(1) << fb) - VALUE_W'(1);

    always_comb
    begin
        item.neg   = value[VALUE_W-1];
        item.whole = mag >> fb;
        item.frac  = mag & mask;
        item.fb    = fb;
        item.radix = radix;
        if (int'(frac_digits) > MAX_FRAC_DIGITS)
        begin
            item.lim = LIM_W'(MAX_FRAC_DIGITS);
        end
        else
        begin
            item.lim = frac_digits;
        end
        priority if (int'(frac_bits) > MAX_FRAC_BITS)
        begin
            item.err = ERR_FRAC_BITS;
        end
        else if (int'(radix) < MIN_RADIX)
        begin
            item.err = ERR_RADIX_LOW;
        end
        else if (int'(radix) > MAX_RADIX)
        begin
            item.err = ERR_RADIX_HIGH;
        end
        else
        begin
            item.err = ERR_NONE;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fptrt_queue.sv
// Short queue of classified requests between the front end and the digit engine.
// Depends on fptrt_pkg.
`default_nettype none

module fptrt_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  fptrt_pkg::conv_item_t      push_item,
    input  wire logic                  pop,
    output fptrt_pkg::conv_item_t      head_item,
    output logic                       full,
    output logic                       not_empty
);
    import fptrt_pkg::*;

    conv_item_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] wr_ptr_reg;
    logic [QUEUE_IDX_W-1:0] wr_ptr_next;
    logic [QUEUE_IDX_W-1:0] rd_ptr_reg;
    logic [QUEUE_IDX_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fptrt_back.sv
// Digit engine: divides out the whole-part digits, then emits sign, digits, point and fraction.
// A bad request gives an error beat instead. Depends on fptrt_pkg; holds the whole-digit store.
`default_nettype none

module fptrt_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  fptrt_pkg::conv_item_t            head_item,
    input  wire logic                        not_empty,
    output logic                             pop,
    output logic [fptrt_pkg::CHAR_W-1:0]     char_code,
    output logic                             is_last,
    output logic [fptrt_pkg::ERR_W-1:0]      error_code,
    output logic                             char_valid
);
    import fptrt_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_SIGN = 7'b0000100,
        ST_DIG  = 7'b0001000,
        ST_DOT  = 7'b0010000,
        ST_FRAC = 7'b0100000,
        ST_ERR  = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    err_t                    err_reg, err_next;
    logic                    neg_reg, neg_next;
    logic [VALUE_W-1:0]      frac_reg, frac_next;
    logic [FB_W-1:0]         fb_reg, fb_next;
    logic [RADIX_W-1:0]      rad_reg, rad_next;
    logic [LIM_W-1:0]        lim_reg, lim_next;
    logic [VALUE_W-1:0]      work_reg, work_next;
    logic [RADIX_W-1:0]      rem_reg, rem_next;
    logic [DIV_STEP_W-1:0]   step_reg, step_next;
    logic [DIGIT_CNT_W-1:0]  count_reg, count_next;
    logic [DIGIT_IDX_W-1:0]  ptr_reg, ptr_next;
    logic [LIM_W-1:0]        fcnt_reg, fcnt_next;
    logic [CHAR_W-1:0]       char_reg, char_next;
    logic                    last_reg, last_next;
    err_t                    oerr_reg, oerr_next;
    logic                    valid_reg, valid_next;

    logic [DIGIT_W-1:0]      digit_mem [DIGIT_DEPTH];
    logic [DIGIT_W-1:0]      rd_data_reg;
    logic [DIGIT_IDX_W-1:0]  rd_addr;
    logic                    dig_we;

    logic [VALUE_W-1:0]      div_work;
    logic [RADIX_W-1:0]      div_rem;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-1:0]       prod_mask;
    logic [PROD_W-1:0]       prod_shift;
    logic [VALUE_W-1:0]      frac_new;
    logic [LIM_W:0]          fcnt_inc;

    always_comb
    begin
        logic [VALUE_W-1:0] w;
        logic [RADIX_W-1:0] r;
        w = work_reg;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
        begin
            r = {r[RADIX_W-2:0], w[VALUE_W-1]};
            w = {w[VALUE_W-2:0], 1'b0};
            if (r >= rad_reg)
            begin
                r    = r - rad_reg;
                w[0] = 1'b1;
            end
        end
        div_work = w;
        div_rem  = r;
    end

    assign prod       = PROD_W'(frac_reg) * PROD_W'(rad_reg);
    assign prod_mask  = (PROD_W'(1) << fb_reg) - PROD_W'(1);
    assign prod_shift = prod >> fb_reg;
    assign frac_new   = VALUE_W'(prod & prod_mask);
    assign fcnt_inc   = {1'b0, fcnt_reg} + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        neg_next   = neg_reg;
        frac_next  = frac_reg;
        fb_next    = fb_reg;
        rad_next   = rad_reg;
        lim_next   = lim_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        fcnt_next  = fcnt_reg;
        char_next  = CHAR_NONE;
        last_next  = 1'b0;
        oerr_next  = ERR_NONE;
        valid_next = 1'b0;
        rd_addr    = ptr_reg;
        dig_we     = 1'b0;
        pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (not_empty)
                begin
                    pop        = 1'b1;
                    err_next   = head_item.err;
                    neg_next   = head_item.neg;
                    frac_next  = head_item.frac;
                    fb_next    = head_item.fb;
                    rad_next   = head_item.radix;
                    lim_next   = head_item.lim;
                    work_next  = head_item.whole;
                    rem_next   = '0;
                    step_next  = '0;
                    count_next = '0;
                    fcnt_next  = '0;
                    state_next = (head_item.err != ERR_NONE) ? ST_ERR : ST_DIV;
                end
            end
            ST_DIV:
            begin
                work_next = div_work;
                rem_next  = div_rem;
                step_next = step_reg + 1'b1;
                if (int'(step_reg) == DIV_CYCLES - 1)
                begin
                    dig_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    rem_next   = '0;
                    step_next  = '0;
                    if (div_work == '0 || int'(count_reg) == DIGIT_DEPTH - 1)
                    begin
                        ptr_next   = count_reg[DIGIT_IDX_W-1:0];
                        state_next = ST_SIGN;
                    end
                end
            end
            ST_SIGN:
            begin
                rd_addr    = ptr_reg;
                valid_next = neg_reg;
                char_next  = CHAR_MINUS;
                state_next = ST_DIG;
            end
            ST_DIG:
            begin
                valid_next = 1'b1;
                char_next  = digit_char(rd_data_reg);
                if (ptr_reg == '0)
                begin
                    state_next = ST_DOT;
                end
                else
                begin
                    ptr_next = ptr_reg - 1'b1;
                    rd_addr  = ptr_reg - 1'b1;
                end
            end
            ST_DOT:
            begin
                valid_next = 1'b1;
                char_next  = CHAR_POINT;
                last_next  = (frac_reg == '0) || (lim_reg == '0);
                state_next = last_next ? ST_IDLE : ST_FRAC;
            end
            ST_FRAC:
            begin
                valid_next = 1'b1;
                char_next  = digit_char(prod_shift[DIGIT_W-1:0]);
                frac_next  = frac_new;
                fcnt_next  = fcnt_inc[LIM_W-1:0];
                last_next  = (frac_new == '0) || (fcnt_inc >= {1'b0, lim_reg});
                state_next = last_next ? ST_IDLE : ST_FRAC;
            end
            ST_ERR:
            begin
                valid_next = 1'b1;
                char_next  = CHAR_NONE;
                last_next  = 1'b1;
                oerr_next  = err_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            count_reg <= '0;
            step_reg  <= '0;
            ptr_reg   <= '0;
            fcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            ptr_reg   <= ptr_next;
            fcnt_reg  <= fcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg  <= err_next;
        neg_reg  <= neg_next;
        frac_reg <= frac_next;
        fb_reg   <= fb_next;
        rad_reg  <= rad_next;
        lim_reg  <= lim_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
        oerr_reg <= oerr_next;
    end

    always_ff @(posedge clk)
    begin
        if (dig_we)
        begin
            digit_mem[count_reg[DIGIT_IDX_W-1:0]] <= div_rem[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= digit_mem[rd_addr];
    end

    assign char_code  = char_reg;
    assign is_last    = last_reg;
    assign error_code = oerr_reg;
    assign char_valid = valid_reg;

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && oerr_reg != ERR_NONE) |-> last_reg)
        else $error("error beat not flagged as last");

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < rad_reg))
        else $error("division remainder not below radix");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= DIGIT_DEPTH)
        else $error("whole digit count beyond store depth");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_reg) |=> !valid_reg)
        else $error("beat directly after last beat");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE && not_empty))
        else $error("queue popped outside idle");

endmodule

`default_nettype wire

// File: hw/rtl/fixed_point_to_radix_text.sv
// Top level of the fixed-point to radix text converter.
// Depends on fptrt_pkg, fptrt_front, fptrt_queue and fptrt_back.
//
// A request is taken at a rising edge where start is high and busy is low. It carries a
// signed 32-bit value, the binary point position, the radix and a fraction digit limit.
// The request is checked and split into sign, whole and fraction at once and placed in a
// two-entry queue; busy is high only while that queue is full.
// The digit engine takes one queued request at a time. Each whole digit is one full division
// of the remaining whole part in an eight-bit-per-cycle restoring divider, and fraction
// digits come one per cycle from a 32 by 5 bit multiply.
// Characters leave in reading order, one beat per cycle while char_valid is high, with
// is_last on the final beat. The receiver cannot stall, so each beat is shown exactly once.
// A request with a bad point position or radix gives a single last beat with character
// zero and the error code.
// Reset empties the queue and returns the engine to idle; the digit store is not cleared.
`default_nettype none

module fixed_point_to_radix_text (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [fptrt_pkg::VALUE_W-1:0]       value,
    input  wire logic [fptrt_pkg::FB_IN_W-1:0]       frac_bits,
    input  wire logic [fptrt_pkg::RADIX_W-1:0]       radix,
    input  wire logic [fptrt_pkg::LIM_W-1:0]         frac_digits,
    output logic [fptrt_pkg::CHAR_W-1:0]             char_code,
    output logic                                     is_last,
    output logic [fptrt_pkg::ERR_W-1:0]              error_code,
    output logic                                     char_valid
);
    import fptrt_pkg::*;

    conv_item_t new_item;
    conv_item_t head_item;
    logic       queue_full;
    logic       queue_not_empty;
    logic       queue_pop;

    assign busy = queue_full;

    fptrt_front u_front (
        .value       (value),
        .frac_bits   (frac_bits),
        .radix       (radix),
        .frac_digits (frac_digits),
        .item        (new_item)
    );

    fptrt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start),
        .push_item (new_item),
        .pop       (queue_pop),
        .head_item (head_item),
        .full      (queue_full),
        .not_empty (queue_not_empty)
    );

    fptrt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .not_empty  (queue_not_empty),
        .pop        (queue_pop),
        .char_code  (char_code),
        .is_last    (is_last),
        .error_code (error_code),
        .char_valid (char_valid)
    );

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// Testbench for fixed_point_to_radix_text: directed table, then random requests with idle gaps.
// Predicts each character beat from typed row text or its own model; depends on fptrt_pkg.

module tb;
    import fptrt_pkg::*;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
        err_t              err;
    } text_beat_t;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [FB_IN_W-1:0] fb;
        logic [RADIX_W-1:0] radix;
        logic [LIM_W-1:0]   lim;
        bit                 typed;
        string              text;
        err_t               err;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [VALUE_W-1:0]   value;
    logic [FB_IN_W-1:0]   frac_bits;
    logic [RADIX_W-1:0]   radix;
    logic [LIM_W-1:0]     frac_digits;
    logic [CHAR_W-1:0]    char_code;
    logic                 is_last;
    logic [ERR_W-1:0]     error_code;
    logic                 char_valid;

    text_beat_t           pending_text[$];
    int                   mismatches = 0;
    int                   idle_pct;
    bit                   row_typed;
    string                row_text;
    err_t                 row_err;

    logic [DIGIT_W-1:0]   digit_hold [DIGIT_DEPTH];
    logic [VALUE_W-1:0]   whole_left;
    logic [PROD_W-1:0]    frac_left;
    logic [DIGIT_CNT_W-1:0] whole_count;

    stim_row_t directed_rows [25] = '{
        '{32'h0000_0000, 6'd0,  5'd10, 4'd0,  1'b1, "0.",         ERR_NONE},
        '{32'h7fff_ffff, 6'd0,  5'd16, 4'd15, 1'b1, "7fffffff.",  ERR_NONE},
        '{32'h8000_0000, 6'd0,  5'd16, 4'd15, 1'b1, "-80000000.", ERR_NONE},
        '{32'h8000_0000, 6'd31, 5'd2,  4'd15, 1'b1, "-1.",        ERR_NONE},
        '{32'hffff_ffff, 6'd0,  5'd2,  4'd15, 1'b1, "-1.",        ERR_NONE},
        '{32'h0001_8000, 6'd16, 5'd10, 4'd4,  1'b1, "1.5",        ERR_NONE},
        '{32'h0001_8000, 6'd16, 5'd10, 4'd0,  1'b1, "1.",         ERR_NONE},
        '{32'hfffe_c000, 6'd16, 5'd10, 4'd15, 1'b1, "-1.25",      ERR_NONE},
        '{32'hffff_ffff, 6'd8,  5'd10, 4'd3,  1'b1, "-0.003",     ERR_NONE},
        '{32'h0000_00ab, 6'd4,  5'd16, 4'd15, 1'b1, "a.b",        ERR_NONE},
        '{32'h0000_00ff, 6'd0,  5'd10, 4'd9,  1'b1, "255.",       ERR_NONE},
        '{32'h1234_5678, 6'd32, 5'd10, 4'd5,  1'b1, "",           ERR_FRAC_BITS},
        '{32'h8000_0000, 6'd63, 5'd0,  4'd15, 1'b1, "",           ERR_FRAC_BITS},
        '{32'h0000_0001, 6'd0,  5'd0,  4'd0,  1'b1, "",           ERR_RADIX_LOW},
        '{32'hffff_ffff, 6'd31, 5'd1,  4'd15, 1'b1, "",           ERR_RADIX_LOW},
        '{32'h0000_0064, 6'd2,  5'd17, 4'd3,  1'b1, "",           ERR_RADIX_HIGH},
        '{32'h7fff_ffff, 6'd31, 5'd31, 4'd15, 1'b1, "",           ERR_RADIX_HIGH},
        '{32'h7fff_ffff, 6'd0,  5'd2,  4'd15, 1'b0, "",           ERR_NONE},
        '{32'h0000_0001, 6'd31, 5'd2,  4'd15, 1'b0, "",           ERR_NONE},
        '{32'h7fff_ffff, 6'd31, 5'd16, 4'd15, 1'b0, "",           ERR_NONE},
        '{32'h0000_0001, 6'd1,  5'd3,  4'd15, 1'b0, "",           ERR_NONE},
        '{32'h1234_5678, 6'd20, 5'd7,  4'd15, 1'b0, "",           ERR_NONE},
        '{32'h8000_0001, 6'd13, 5'd16, 4'd15, 1'b0, "",           ERR_NONE},
        '{32'h5555_5555, 6'd31, 5'd2,  4'd15, 1'b0, "",           ERR_NONE},
        '{32'hc000_0000, 6'd30, 5'd5,  4'd15, 1'b0, "",           ERR_NONE}
    };

    fixed_point_to_radix_text dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .frac_bits   (frac_bits),
        .radix       (radix),
        .frac_digits (frac_digits),
        .char_code   (char_code),
        .is_last     (is_last),
        .error_code  (error_code),
        .char_valid  (char_valid)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("check failed at %0t ns: %s", $time, what);
    endtask

    function automatic void push_beat(input logic [CHAR_W-1:0] code, input logic last,
                                      input err_t err);
        text_beat_t beat;
        beat.code = code;
        beat.last = last;
        beat.err = err;
        pending_text.push_back(beat);
    endfunction

    function automatic logic [CHAR_W-1:0] ascii_digit(input logic [DIGIT_W-1:0] d);
        return (d < 4'd10) ? "0" + CHAR_W'(d) : "a" + CHAR_W'(d) - CHAR_W'(10);
    endfunction

    function automatic void expect_typed(input string text, input err_t err);
        if (err != ERR_NONE)
            push_beat(CHAR_NONE, 1'b1, err);
        else
            for (int i = 0; i < text.len(); i++)
                push_beat(text[i], i == text.len() - 1, ERR_NONE);
    endfunction

    function automatic void predict_text(input logic [VALUE_W-1:0] v,
                                         input logic [FB_IN_W-1:0] fb,
                                         input logic [RADIX_W-1:0] rad,
                                         input logic [LIM_W-1:0] lim);
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [63:0]        mask;
        logic [LIM_W-1:0]   cap;
        logic [DIGIT_W-1:0] d;
        int                 cnt;
        if (fb > MAX_FRAC_BITS)
        begin
            push_beat(CHAR_NONE, 1'b1, ERR_FRAC_BITS);
            return;
        end
        if (rad < MIN_RADIX)
        begin
            push_beat(CHAR_NONE, 1'b1, ERR_RADIX_LOW);
            return;
        end
        if (rad > MAX_RADIX)
        begin
            push_beat(CHAR_NONE, 1'b1, ERR_RADIX_HIGH);
            return;
        end
        cap = (lim > MAX_FRAC_DIGITS) ? LIM_W'(MAX_FRAC_DIGITS) : lim;
        neg = v[VALUE_W-1];
        mag = neg ? (~v + 1'b1) : v;
        mask = (64'd1 << fb) - 64'd1;
        whole_left = mag >> fb;
        frac_left = PROD_W'(mag & mask[VALUE_W-1:0]);
        whole_count = '0;
        do
        begin
            digit_hold[whole_count[DIGIT_IDX_W-1:0]] = DIGIT_W'(whole_left % rad);
            whole_left = whole_left / rad;
            whole_count++;
        end
        while (whole_left != 0 && whole_count < DIGIT_DEPTH);
        if (neg)
            push_beat(CHAR_MINUS, 1'b0, ERR_NONE);
        for (int k = whole_count; k > 0; k--)
            push_beat(ascii_digit(digit_hold[k-1]), 1'b0, ERR_NONE);
        push_beat(CHAR_POINT, frac_left == 0 || cap == 0, ERR_NONE);
        cnt = 0;
        while (frac_left != 0 && cnt < cap)
        begin
            frac_left = frac_left * rad;
            d = DIGIT_W'(frac_left >> fb);
            frac_left = frac_left & mask[PROD_W-1:0];
            cnt++;
            push_beat(ascii_digit(d), frac_left == 0 || cnt >= cap, ERR_NONE);
        end
    endfunction

    always @(posedge clk)
    begin
        text_beat_t want;
        if (rst_n === 1'b1 && char_valid === 1'b1)
        begin
            if (pending_text.size() == 0)
                report_mismatch($sformatf("beat with nothing pending, char %h", char_code));
            else
            begin
                want = pending_text.pop_front();
                if (char_code !== want.code)
                    report_mismatch($sformatf("char_code %h, want %h", char_code, want.code));
                if (is_last !== want.last)
                    report_mismatch($sformatf("is_last %b, want %b", is_last, want.last));
                if (error_code !== want.err)
                    report_mismatch($sformatf("error_code %0d, want %0d", error_code,
                                              want.err));
            end
        end
        if (rst_n === 1'b1 && start === 1'b1 && busy === 1'b0)
        begin
            if (row_typed)
                expect_typed(row_text, row_err);
            else
                predict_text(value, frac_bits, radix, frac_digits);
        end
    end

    function automatic stim_row_t random_row();
        stim_row_t row;
        int        pick;
        row.typed = 1'b0;
        row.text = "";
        row.err = ERR_NONE;
        row.value = $urandom;
        row.fb = FB_IN_W'($urandom_range(0, MAX_FRAC_BITS));
        row.radix = RADIX_W'($urandom_range(MIN_RADIX, MAX_RADIX));
        row.lim = LIM_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4)
            row.fb = FB_IN_W'($urandom_range(MAX_FRAC_BITS + 1, 63));
        else if (pick < 7)
            row.radix = RADIX_W'($urandom_range(0, MIN_RADIX - 1));
        else if (pick < 10)
            row.radix = RADIX_W'($urandom_range(MAX_RADIX + 1, 31));
        else if (pick < 30)
        begin
            row.value = $urandom_range(0, 1023);
            if ($urandom_range(0, 1))
                row.value = -row.value;
        end
        else if (pick < 40)
        begin
            case ($urandom_range(0, 3))
                0: row.value = 32'h8000_0000;
                1: row.value = 32'h7fff_ffff;
                2: row.value = 32'hffff_ffff;
                default: row.value = row.value & ~((32'd1 << row.fb) - 32'd1);
            endcase
        end
        return row;
    endfunction

    task automatic send_text_item(input stim_row_t row);
        int gap;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
                value <= $urandom;
                frac_bits <= FB_IN_W'($urandom);
                radix <= RADIX_W'($urandom);
                frac_digits <= LIM_W'($urandom);
            end
        end
        @(negedge clk);
        start <= 1'b1;
        value <= row.value;
        frac_bits <= row.fb;
        radix <= row.radix;
        frac_digits <= row.lim;
        row_typed = row.typed;
        row_text = row.text;
        row_err = row.err;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic drain_text();
        @(negedge clk);
        start <= 1'b0;
        while (pending_text.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        start = 1'b0;
        value = '0;
        frac_bits = '0;
        radix = '0;
        frac_digits = '0;
        row_typed = 1'b0;
        row_text = "";
        row_err = ERR_NONE;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        idle_pct = 10;
        foreach (directed_rows[i])
            send_text_item(directed_rows[i]);
        drain_text();

        for (int i = 0; i < 85; i++)
        begin
            if (i == 28 || i == 56)
                drain_text();
            idle_pct = (i < 28) ? 10 : (i < 56) ? 51 : 0;
            send_text_item(random_row());
        end
        drain_text();
        repeat (200) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
